// ===== hw/rtl/fnv_hash_duplicate_filter_unit_assert.svh =====
// Assertion macros for the FNV duplicate filter.
// FHDF_ASSERT checks a property on every rising clock edge outside reset.
// FHDF_NEVER checks that a condition never holds outside reset.
`ifndef FNV_HASH_DUPLICATE_FILTER_UNIT_ASSERT_SVH
`define FNV_HASH_DUPLICATE_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FHDF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("fnv filter assertion failed");
`define FHDF_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("fnv filter condition must never hold");
`else
`define FHDF_ASSERT(lbl, clk, rst_n, prop)
`define FHDF_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/fhdf_pkg.sv =====
// ----------------------------------------------------------------------------
// fhdf_pkg
// Types, constants and the FNV-1a fold step shared by the duplicate filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhdf_pkg;

	localparam int HistDepth = 64;
	localparam int HistAddrW = (HistDepth > 1) ? $clog2(HistDepth) : 1;
	localparam int HistCntW  = $clog2(HistDepth + 1);
	localparam int HashW     = 64;

	localparam logic [HashW-1:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;

	typedef struct packed {
		logic [7:0] id_byte;
		logic       last_byte;
		logic       keep_if_new;
	} in_t;

	typedef struct packed {
		logic             duplicate;
		logic [HashW-1:0] id_hash;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic fold;
		logic finish;
		logic scan_rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic hist_empty;
		logic scan_last;
	} status_t;

	// xor the byte, then multiply by the prime 0x100000001B3 modulo 2^64 as shift-adds
	function automatic logic [HashW-1:0] fnv_fold(input logic [HashW-1:0] h,
		input logic [7:0] b);
		logic [HashW-1:0] x;
		x = h ^ {{(HashW-8){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fhdf_ram.sv =====
// ----------------------------------------------------------------------------
// fhdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhdf_ram #(
	parameter int Width = 64,
	parameter int Depth = 64,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fhdf_datapath.sv =====
// ----------------------------------------------------------------------------
// fhdf_datapath
// Running hash, history RAM with fill count, scan compare and FIFO write slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhdf_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fhdf_pkg::in_t     id_in,
	input  wire fhdf_pkg::cmd_t    cmd,
	output fhdf_pkg::status_t      status,
	output fhdf_pkg::out_t         result
);
	import fhdf_pkg::*;
	`include "fnv_hash_duplicate_filter_unit_assert.svh"

	logic [HashW-1:0]     running_q;
	logic [HashW-1:0]     hash_q;
	logic                 keep_q;
	logic                 match_q;
	logic                 rd_vld_q;
	logic [HistAddrW-1:0] idx_q;
	logic [HistAddrW-1:0] slot_q;
	logic [HistCntW-1:0]  fill_q;
	logic [HashW-1:0]     folded;
	logic [HashW-1:0]     rd_data;
	logic                 wr_en;

	assign folded = fnv_fold(running_q, id_in.id_byte);
	assign wr_en  = cmd.commit && !match_q && keep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= FnvBasis;
			match_q   <= 1'b0;
			rd_vld_q  <= 1'b0;
			idx_q     <= '0;
			slot_q    <= '0;
			fill_q    <= '0;
		end else begin
			rd_vld_q <= cmd.scan_rd;
			if (cmd.finish) begin
				running_q <= FnvBasis;
				match_q   <= 1'b0;
				idx_q     <= '0;
			end else if (cmd.fold) begin
				running_q <= folded;
			end
			if (cmd.scan_rd) begin
				idx_q <= idx_q + HistAddrW'(1);
			end
			if (rd_vld_q && rd_data == hash_q) begin
				match_q <= 1'b1;
			end
			// oldest slot is overwritten; fill count saturates at depth
			if (wr_en) begin
				slot_q <= (slot_q == HistAddrW'(HistDepth - 1)) ? '0
					: slot_q + HistAddrW'(1);
				if (fill_q != HistCntW'(HistDepth)) begin
					fill_q <= fill_q + HistCntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			hash_q <= folded | {{(HashW-1){1'b0}}, 1'b1};
			keep_q <= id_in.keep_if_new;
		end
	end

	fhdf_ram #(
		.Width(HashW),
		.Depth(HistDepth)
	) u_hist (
		.clk  (clk),
		.we   (wr_en),
		.waddr(slot_q),
		.wdata(hash_q),
		.re   (cmd.scan_rd),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign status.hist_empty = (fill_q == '0);
	assign status.scan_last  = (HistCntW'(idx_q) + HistCntW'(1) == fill_q);

	assign result.duplicate = match_q;
	assign result.id_hash   = hash_q;

	`FHDF_NEVER(a_fill_range, clk, arst_n, fill_q > HistCntW'(HistDepth))
	`FHDF_ASSERT(a_hash_odd, clk, arst_n, cmd.commit |-> hash_q[0])
	`FHDF_ASSERT(a_write_fills, clk, arst_n, wr_en |=> fill_q != '0)

endmodule

`default_nettype wire

// ===== hw/rtl/fhdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// fhdf_ctrl
// Sequencer: takes bytes, scans a non-empty history on a final byte, then reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhdf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              last_byte,
	input  wire fhdf_pkg::status_t status,
	output fhdf_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   done
);
	import fhdf_pkg::*;
	`include "fnv_hash_duplicate_filter_unit_assert.svh"

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && last_byte) begin
					state_nxt = status.hist_empty ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_nxt = ST_TAIL;
				end
			end
			ST_TAIL:   state_nxt = ST_DECIDE;
			ST_DECIDE: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = (state_q != ST_IDLE);
		cmd.fold    = start && (state_q == ST_IDLE);
		cmd.finish  = start && last_byte && (state_q == ST_IDLE);
		cmd.scan_rd = (state_q == ST_SCAN);
		cmd.commit  = (state_q == ST_DECIDE);
		done        = (state_q == ST_DECIDE);
	end

	`FHDF_ASSERT(a_done_frees, clk, arst_n, done |=> !busy)
	`FHDF_ASSERT(a_finish_busy, clk, arst_n, cmd.finish |=> busy)
	`FHDF_NEVER(a_read_on_commit, clk, arst_n, cmd.scan_rd && cmd.commit)

endmodule

`default_nettype wire

// ===== hw/rtl/fnv_hash_duplicate_filter_unit.sv =====
// ----------------------------------------------------------------------------
// fnv_hash_duplicate_filter_unit
// FNV-1a 64-bit identifier hash with a FIFO history duplicate check.
// ----------------------------------------------------------------------------
// A non-final byte is folded into the running hash and gives no result; busy stays low.
// A final byte holds busy through a scan of the N filled history slots (1 to 64),
// one slot read per cycle, then ST_TAIL and ST_DECIDE, or through ST_DECIDE alone while the history is empty.
// done pulses for one cycle with the result in ST_DECIDE, the last busy state.
// The receiver cannot stall. Reset empties the history (fill count to zero)
// and reloads the running hash with the offset basis at once.
`timescale 1ns / 1ps
`default_nettype none

module fnv_hash_duplicate_filter_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire fhdf_pkg::in_t  id_in,
	output logic                busy,
	output logic                done,
	output fhdf_pkg::out_t      result
);
	import fhdf_pkg::*;

	cmd_t    cmd;
	status_t status;

	fhdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_byte(id_in.last_byte),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	fhdf_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.id_in (id_in),
		.cmd   (cmd),
		.status(status),
		.result(result)
	);

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the FNV-1a duplicate filter: identifiers are fed byte
// by byte with random gaps, and every verdict is checked against a
// cycle-free model of the running hash and the FIFO history.
// ----------------------------------------------------------------------------

module tb_top;

	import fhdf_pkg::*;

	localparam logic [HashW-1:0] FnvPrime = 64'h0000_0100_0000_01B3;
	localparam int PoolSize = 96;
	localparam int MaxIdLen = 8;
	localparam int ByteTarget = 600;

	typedef logic [7:0] ident_t [MaxIdLen];

	// Model of hash, history and verdict order.
	class fnv_history_model;
		logic [HashW-1:0] running_hash;
		logic [HashW-1:0] recent [HistDepth];
		int unsigned      oldest;
		out_t             pending_verdicts [$];
		int               errors;

		function new();
			running_hash = FnvBasis;
			foreach (recent[i])
				recent[i] = '0;
			oldest = 0;
			errors = 0;
		endfunction

		function void take_byte(in_t item);
			logic [HashW-1:0] h;
			bit               seen;
			out_t             verdict;
			running_hash = (running_hash ^ {56'd0, item.id_byte}) * FnvPrime;
			if (item.last_byte) begin
				h = running_hash | 64'd1;
				running_hash = FnvBasis;
				seen = 1'b0;
				foreach (recent[i])
					if (recent[i] == h)
						seen = 1'b1;
				// record only new hashes, overwrite the oldest slot
				if (!seen && item.keep_if_new) begin
					recent[oldest] = h;
					oldest = (oldest + 1) % HistDepth;
				end
				verdict.duplicate = seen;
				verdict.id_hash = h;
				pending_verdicts.push_back(verdict);
			end
		endfunction

		function void check_verdict(out_t got);
			out_t want;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, got dup=%0b hash=%h",
					$time, got.duplicate, got.id_hash);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.duplicate !== want.duplicate) begin
				$display("%0t: duplicate flag mismatch, expected %0b, got %0b",
					$time, want.duplicate, got.duplicate);
				errors++;
			end
			if (got.id_hash !== want.id_hash) begin
				$display("%0t: id_hash mismatch, expected %h, got %h",
					$time, want.id_hash, got.id_hash);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	in_t  id_in;
	logic busy;
	logic done;
	out_t result;

	fnv_history_model board;
	int               quiet_left;
	int               bytes_sent;
	ident_t           pool_ids [PoolSize];
	int               pool_len [PoolSize];

	fnv_hash_duplicate_filter_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.id_in  (id_in),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_verdict(result);
	end

	// Call at a rising edge; returns at the edge that accepts the transfer.
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic keep);
		int   gap;
		in_t  item;
		item.id_byte = b;
		item.last_byte = fin;
		item.keep_if_new = keep;
		if (quiet_left > 0) begin
			gap = 0;
			quiet_left--;
		end else begin
			gap = $urandom_range(0, 8);
			if ($urandom_range(0, 29) == 0)
				quiet_left = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		id_in <= item;
		// busy only moves at a rising edge, so the falling edge shows its value
		do @(negedge clk); while (busy);
		@(posedge clk);
		board.take_byte(item);
		bytes_sent++;
	endtask

	task automatic send_ident(input ident_t bytes_in, input int len, input logic keep);
		for (int i = 0; i < len; i++) begin
			if (i == len - 1)
				send_byte(bytes_in[i], 1'b1, keep);
			else
				send_byte(bytes_in[i], 1'b0, 1'($urandom_range(0, 1)));
		end
	endtask

	// Hold start low until every verdict has come back.
	task automatic drain_verdicts();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	function automatic int draw_len();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(5, MaxIdLen)
			: $urandom_range(1, 4);
	endfunction

	initial begin
		ident_t scratch;
		int     pick;
		int     len;
		int     next_pause;

		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		id_in = '0;
		quiet_left = 0;
		bytes_sent = 0;
		foreach (pool_ids[k]) begin
			pool_len[k] = draw_len();
			foreach (pool_ids[k][j])
				pool_ids[k][j] = 8'($urandom_range(0, 255));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// single-byte extremes: new and kept, then seen again
		scratch[0] = 8'h00;
		send_ident(scratch, 1, 1'b1);
		send_ident(scratch, 1, 1'b1);
		// new but not kept, so it stays new
		scratch[0] = 8'hFF;
		send_ident(scratch, 1, 1'b0);
		send_ident(scratch, 1, 1'b1);
		send_ident(scratch, 1, 1'b0);
		// multi-byte: keep on inner bytes is ignored
		scratch[0] = 8'h12;
		scratch[1] = 8'h34;
		scratch[2] = 8'hAB;
		send_byte(scratch[0], 1'b0, 1'b1);
		send_byte(scratch[1], 1'b0, 1'b1);
		send_byte(scratch[2], 1'b1, 1'b0);
		send_ident(scratch, 3, 1'b1);
		// duplicate with keep set leaves the history alone
		send_ident(scratch, 3, 1'b1);
		scratch[0] = 8'hFF;
		scratch[1] = 8'h00;
		send_ident(scratch, 2, 1'b1);
		drain_verdicts();

		// pooled identifiers give duplicates and, past 64 kept, evictions
		next_pause = bytes_sent + 150;
		while (bytes_sent < ByteTarget) begin
			if ($urandom_range(0, 9) < 7) begin
				pick = $urandom_range(0, PoolSize - 1);
				send_ident(pool_ids[pick], pool_len[pick], 1'($urandom_range(0, 3) != 0));
			end else begin
				len = draw_len();
				foreach (scratch[j])
					scratch[j] = 8'($urandom_range(0, 255));
				send_ident(scratch, len, 1'($urandom_range(0, 1)));
			end
			if (bytes_sent >= next_pause) begin
				drain_verdicts();
				next_pause = bytes_sent + 150;
			end
		end

		drain_verdicts();
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
